### hw/rtl/min_cost_assignment_solver_assert.svh
// ----------------------------------------------------------------------------
// min_cost_assignment_solver assertion macros
// Shared clocking and reporting form for the concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef MIN_COST_ASSIGNMENT_SOLVER_ASSERT_SVH
`define MIN_COST_ASSIGNMENT_SOLVER_ASSERT_SVH

// Clocking event with the synchronous active-low reset as disable.
`define MCAS_CLK_RST(clk, rst_n) @(posedge clk) disable iff (!rst_n)

// One labeled concurrent assertion that reports through $error.
`define MCAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (`MCAS_CLK_RST(clk, rst_n) prop) else $error(msg);

`endif

### hw/rtl/mcas_pkg.sv
// ----------------------------------------------------------------------------
// mcas_pkg
// Types, codes and constants shared by the assignment solver modules.
// ----------------------------------------------------------------------------
package mcas_pkg;

    localparam int MAX_SIZE_DEF  = 16;
    localparam int COST_BITS_DEF = 16;

    localparam int SIZE_W     = 5;
    localparam int IN_IDX_W   = 4;
    localparam int OUT_IDX_W  = 4;
    localparam int TOTAL_W    = 20;
    localparam int OUT_PAD_W  = 4;
    localparam int OUT_DATA_W = 2 * OUT_IDX_W + TOTAL_W + OUT_PAD_W;

    localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = 5'd16;

    typedef enum logic [4:0] {
        S_LOAD, S_CM_RD, S_CM_MIN, S_CS_RD, S_CS_WR, S_INIT,
        S_GR_RD, S_GR_MIN, S_GM_RD, S_GM_CHK, S_LEFT,
        S_SC_ROW, S_SC_RD, S_SC_COL, S_MN, S_MN_END, S_RR, S_UP,
        S_AUG, S_AUG_DONE, S_RS,
        S_CK_RD, S_CK_USE, S_CK2_SET, S_CK2_RD, S_CK2_USE,
        S_TOT, S_OUT, S_FAIL
    } t_state;

    typedef enum logic [4:0] {
        C_LOAD, C_CM_RD, C_CM_MIN, C_CS_RD, C_CS_WR, C_INIT,
        C_GR_RD, C_GR_MIN, C_GM_RD, C_GM_CHK, C_LEFT,
        C_SC_ROW, C_SC_RD, C_SC_COL, C_MN, C_MN_END, C_RR, C_UP,
        C_AUG, C_AUG_DONE, C_RS,
        C_CK_RD, C_CK_USE, C_CK2_SET, C_CK2_RD, C_CK2_USE,
        C_TOT, C_OUT, C_FAIL
    } t_cmd;

    typedef struct packed {
        logic in_last_fire;
        logic out_fire;
        logic r_end;
        logic c_end;
        logic x_end;
        logic head_more;
        logic cnt_zero;
        logic left_one;
        logic gm_match;
        logic sc_hit;
        logic up_hit;
        logic mn_top;
        logic aug_bad;
        logic aug_end;
        logic ck_fail;
        logic ck2_bad;
        logic ck2_fail;
    } t_status;

endpackage

### hw/rtl/min_cost_assignment_solver.sv
// ----------------------------------------------------------------------------
// min_cost_assignment_solver
// Minimum-cost perfect assignment of a square cost matrix (Hungarian method).
// ----------------------------------------------------------------------------
// Cost entries are loaded one word per cycle, each written to its row and
// column of an on-chip store; the word flagged with tlast starts the solve,
// and no further word is taken until every result of that run has been
// delivered. Solving runs on a sequencer that reads stored costs one at a
// time through the single registered port of the cost store; a run steps
// through column reduction, greedy matching, row scans and dual updates
// while the alternating forests grow, the dual check and the total, then
// gives n result words (or one flagged word when the run fails). The matrix
// size register is written with i_cfg_we; the user must write it only while
// the block is idle, which the block itself does not enforce. Sizes of zero
// act as one and sizes above MAX_SIZE act as MAX_SIZE. The store keeps the
// column-reduced costs after a run, so a later run that reloads only part of
// the matrix solves on those.
module min_cost_assignment_solver #(
    parameter int MAX_SIZE  = mcas_pkg::MAX_SIZE_DEF,
    parameter int COST_BITS = mcas_pkg::COST_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Matrix size register write.
    input  logic                               i_cfg_we,
    input  logic [mcas_pkg::SIZE_W-1:0]        i_cfg_wdata,
    // Cost entry words.
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata, lowest bit up: row_index[3:0], col_index[7:4],
    // cost_value[COST_BITS+7:8], zero fill to whole bytes.
    input  logic [((2*mcas_pkg::IN_IDX_W+COST_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    // tlast carries last_entry.
    input  logic                               i_s_axis_tlast,
    // Result words.
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata, lowest bit up: out_row[3:0], assigned_col[7:4],
    // total_cost[27:8], zero fill [31:28].
    output logic [mcas_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // tuser carries failed.
    output logic                               o_m_axis_tuser,
    // tlast carries last_result.
    output logic                               o_m_axis_tlast
);
    import mcas_pkg::*;

    // Command from the sequencer and the conditions it branches on.
    t_cmd    w_cmd;
    t_status w_status;

    mcas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // The datapath owns the cost store, duals, slacks, matching and ports.
    mcas_datapath #(
        .MAX_SIZE  (MAX_SIZE),
        .COST_BITS (COST_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cmd           (w_cmd),
        .o_status        (w_status)
    );

endmodule

### hw/rtl/mcas_ctrl.sv
// ----------------------------------------------------------------------------
// mcas_ctrl
// Sequencer for the solver: steps through loading, reduction, matching,
// forest growth, augmenting, checking and result output.
// ----------------------------------------------------------------------------
module mcas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mcas_pkg::t_status i_status,
    output mcas_pkg::t_cmd    o_cmd
);
    import mcas_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = C_LOAD;
        unique case (r_state)
            S_LOAD: begin
                o_cmd = C_LOAD;
                if (i_status.in_last_fire) n_state = S_CM_RD;
            end
            S_CM_RD: begin
                o_cmd   = C_CM_RD;
                n_state = S_CM_MIN;
            end
            S_CM_MIN: begin
                o_cmd   = C_CM_MIN;
                n_state = i_status.r_end ? S_CS_RD : S_CM_RD;
            end
            S_CS_RD: begin
                o_cmd   = C_CS_RD;
                n_state = S_CS_WR;
            end
            S_CS_WR: begin
                o_cmd = C_CS_WR;
                if (i_status.r_end) begin
                    n_state = i_status.c_end ? S_INIT : S_CM_RD;
                end else begin
                    n_state = S_CS_RD;
                end
            end
            S_INIT: begin
                o_cmd   = C_INIT;
                n_state = S_GR_RD;
            end
            S_GR_RD: begin
                o_cmd   = C_GR_RD;
                n_state = S_GR_MIN;
            end
            S_GR_MIN: begin
                o_cmd   = C_GR_MIN;
                n_state = i_status.c_end ? S_GM_RD : S_GR_RD;
            end
            S_GM_RD: begin
                o_cmd   = C_GM_RD;
                n_state = S_GM_CHK;
            end
            S_GM_CHK: begin
                o_cmd = C_GM_CHK;
                if (i_status.gm_match || i_status.c_end) begin
                    n_state = i_status.r_end ? S_LEFT : S_GR_RD;
                end else begin
                    n_state = S_GM_RD;
                end
            end
            S_LEFT: begin
                o_cmd   = C_LEFT;
                n_state = i_status.cnt_zero ? S_CK_RD : S_SC_ROW;
            end
            S_SC_ROW: begin
                o_cmd   = C_SC_ROW;
                n_state = i_status.head_more ? S_SC_RD : S_MN;
            end
            S_SC_RD: begin
                o_cmd   = C_SC_RD;
                n_state = S_SC_COL;
            end
            S_SC_COL: begin
                o_cmd = C_SC_COL;
                priority if (i_status.sc_hit) n_state = S_AUG;
                else if (i_status.c_end)      n_state = S_SC_ROW;
                else                          n_state = S_SC_RD;
            end
            S_MN: begin
                o_cmd   = C_MN;
                n_state = i_status.c_end ? S_MN_END : S_MN;
            end
            S_MN_END: begin
                o_cmd = C_MN_END;
                priority if (i_status.mn_top) n_state = S_FAIL;
                else if (i_status.cnt_zero)   n_state = S_UP;
                else                          n_state = S_RR;
            end
            S_RR: begin
                o_cmd   = C_RR;
                n_state = i_status.x_end ? S_UP : S_RR;
            end
            S_UP: begin
                o_cmd = C_UP;
                priority if (i_status.up_hit) n_state = S_AUG;
                else if (i_status.c_end)      n_state = S_SC_ROW;
                else                          n_state = S_UP;
            end
            S_AUG: begin
                o_cmd = C_AUG;
                priority if (i_status.aug_bad) n_state = S_FAIL;
                else if (i_status.aug_end)     n_state = S_AUG_DONE;
                else                           n_state = S_AUG;
            end
            S_AUG_DONE: begin
                o_cmd   = C_AUG_DONE;
                n_state = i_status.left_one ? S_CK_RD : S_RS;
            end
            S_RS: begin
                o_cmd   = C_RS;
                n_state = i_status.r_end ? S_SC_ROW : S_RS;
            end
            S_CK_RD: begin
                o_cmd   = C_CK_RD;
                n_state = S_CK_USE;
            end
            S_CK_USE: begin
                o_cmd = C_CK_USE;
                priority if (i_status.ck_fail)               n_state = S_FAIL;
                else if (i_status.c_end && i_status.r_end)   n_state = S_CK2_SET;
                else                                         n_state = S_CK_RD;
            end
            S_CK2_SET: begin
                o_cmd   = C_CK2_SET;
                n_state = i_status.ck2_bad ? S_FAIL : S_CK2_RD;
            end
            S_CK2_RD: begin
                o_cmd   = C_CK2_RD;
                n_state = S_CK2_USE;
            end
            S_CK2_USE: begin
                o_cmd = C_CK2_USE;
                priority if (i_status.ck2_fail) n_state = S_FAIL;
                else if (i_status.r_end)        n_state = S_TOT;
                else                            n_state = S_CK2_SET;
            end
            S_TOT: begin
                o_cmd   = C_TOT;
                n_state = i_status.r_end ? S_OUT : S_TOT;
            end
            S_OUT: begin
                o_cmd = C_OUT;
                if (i_status.out_fire && i_status.r_end) n_state = S_LOAD;
            end
            S_FAIL: begin
                o_cmd = C_FAIL;
                if (i_status.out_fire) n_state = S_LOAD;
            end
            default: begin
                o_cmd   = C_LOAD;
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

### hw/rtl/mcas_datapath.sv
// ----------------------------------------------------------------------------
// mcas_datapath
// Cost store, dual and slack arrays, matching arrays, counters and the
// stream ports. Executes one command of the sequencer per cycle.
// ----------------------------------------------------------------------------
module mcas_datapath #(
    parameter int MAX_SIZE  = mcas_pkg::MAX_SIZE_DEF,
    parameter int COST_BITS = mcas_pkg::COST_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mcas_pkg::SIZE_W-1:0]        i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [((2*mcas_pkg::IN_IDX_W+COST_BITS+7)/8)*8-1:0] i_s_axis_tdata,
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [mcas_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tuser,
    output logic                               o_m_axis_tlast,
    input  mcas_pkg::t_cmd                     i_cmd,
    output mcas_pkg::t_status                  o_status
);
    import mcas_pkg::*;

    localparam int IW = $clog2(MAX_SIZE);
    localparam int CW = $clog2(MAX_SIZE + 1);
    localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
    localparam int DW = (COST_BITS + 12 > TOTAL_W + 4) ? COST_BITS + 12 : TOTAL_W + 4;
    // Reduced costs kept across runs can grow past the input range, so the
    // store is as wide as the dual arithmetic.
    localparam int SW = DW;
    localparam logic signed [DW-1:0] SLACK_TOP = {1'b0, {(DW-1){1'b1}}};
    localparam logic [IW:0] NONE = {1'b1, {IW{1'b0}}};

    // Cost store and its registered read port.
    logic signed [SW-1:0] mem [MAX_SIZE*MAX_SIZE];
    logic signed [SW-1:0] r_rdata;

    logic [SIZE_W-1:0]    r_ms;
    logic signed [DW-1:0] r_rr    [MAX_SIZE];
    logic signed [DW-1:0] r_inc   [MAX_SIZE];
    logic signed [DW-1:0] r_slack [MAX_SIZE];
    logic [IW-1:0]        r_src   [MAX_SIZE];
    logic [IW:0]          r_rp    [MAX_SIZE];
    logic [IW:0]          r_cp    [MAX_SIZE];
    logic [IW:0]          r_par   [MAX_SIZE];
    logic [IW-1:0]        r_open  [MAX_SIZE];
    logic signed [DW-1:0] r_sum, r_total, r_m, r_base;
    logic [IW-1:0]        r_r, r_c, r_x;
    logic                 r_rnone;
    logic [CW-1:0]        r_head, r_cnt, r_left;

    logic [CW-1:0]           n_sel;
    logic [IW-1:0]           nm1;
    logic                    in_fire, out_fire, is_fail;
    logic [IN_IDX_W-1:0]     in_row, in_col;
    logic signed [COST_BITS-1:0] in_cost;
    logic signed [DW-1:0]    data_ext, cm_min, gr_min, d, slack_c, slack_sub;
    logic signed [DW-1:0]    mn_new, dual_rc;
    logic                    slack_nz, cp_none, can_push, push_en;
    logic [IW-1:0]           push_val;
    logic [IW:0]             rp_r;
    logic [AW-1:0]           rd_addr, mem_waddr;
    logic                    mem_we;
    logic signed [SW-1:0]    mem_wdata;

    always_comb begin
        if (r_ms == '0) begin
            n_sel = CW'(1);
        end else if (32'(r_ms) > MAX_SIZE) begin
            n_sel = CW'(MAX_SIZE);
        end else begin
            n_sel = CW'(r_ms);
        end
    end
    assign nm1 = IW'(n_sel - CW'(1));

    assign in_row  = i_s_axis_tdata[IN_IDX_W-1:0];
    assign in_col  = i_s_axis_tdata[2*IN_IDX_W-1:IN_IDX_W];
    assign in_cost = i_s_axis_tdata[2*IN_IDX_W +: COST_BITS];

    assign o_s_axis_tready = (i_cmd == C_LOAD);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign is_fail         = (i_cmd == C_FAIL);
    assign o_m_axis_tvalid = (i_cmd == C_OUT) || is_fail;
    assign out_fire        = o_m_axis_tvalid && i_m_axis_tready;

    assign data_ext  = DW'(r_rdata);
    assign cm_min    = (r_r == '0 || data_ext < r_m) ? data_ext : r_m;
    assign gr_min    = (r_c == '0 || data_ext < r_m) ? data_ext : r_m;
    assign slack_c   = r_slack[r_c];
    assign slack_nz  = (slack_c != '0);
    assign cp_none   = r_cp[r_c][IW];
    assign d         = data_ext - r_base + r_inc[r_c];
    assign slack_sub = slack_c - r_m;
    assign mn_new    = (slack_nz && slack_c < r_m) ? slack_c : r_m;
    assign dual_rc   = r_rr[r_r] - r_inc[r_c];
    assign rp_r      = r_rp[r_r];
    assign can_push  = (r_cnt < CW'(MAX_SIZE));

    always_comb begin
        push_en  = 1'b0;
        push_val = r_r;
        unique case (i_cmd)
            C_GM_CHK: push_en = !((data_ext == r_m) && cp_none) && (r_c == nm1);
            C_RS:     push_en = rp_r[IW];
            C_SC_COL: begin
                push_en  = slack_nz && (d < slack_c) && (d == '0) && !cp_none;
                push_val = r_cp[r_c][IW-1:0];
            end
            C_UP: begin
                push_en  = slack_nz && (slack_sub == '0) && !cp_none;
                push_val = r_cp[r_c][IW-1:0];
            end
            default: push_en = 1'b0;
        endcase
    end

    assign rd_addr = AW'(32'(r_r) * MAX_SIZE + 32'(r_c));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = rd_addr;
        mem_wdata = SW'(data_ext - r_m);
        if (i_cmd == C_CS_WR) begin
            mem_we = 1'b1;
        end else if (in_fire && 32'(in_row) < MAX_SIZE && 32'(in_col) < MAX_SIZE) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(32'(in_row) * MAX_SIZE + 32'(in_col));
            mem_wdata = SW'(in_cost);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms <= MATRIX_SIZE_RESET;
            for (int k = 0; k < MAX_SIZE; k++) begin
                r_rr[k]    <= '0;
                r_inc[k]   <= '0;
                r_slack[k] <= SLACK_TOP;
                r_src[k]   <= '0;
                r_rp[k]    <= NONE;
                r_cp[k]    <= NONE;
                r_par[k]   <= NONE;
                r_open[k]  <= '0;
            end
            r_sum   <= '0;
            r_total <= '0;
            r_m     <= '0;
            r_base  <= '0;
            r_r     <= '0;
            r_c     <= '0;
            r_x     <= '0;
            r_rnone <= 1'b0;
            r_head  <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
        end else begin
            if (i_cfg_we) r_ms <= i_cfg_wdata;
            if (push_en && can_push) begin
                r_open[r_cnt[IW-1:0]] <= push_val;
                r_cnt <= r_cnt + CW'(1);
            end
            unique case (i_cmd)
                C_LOAD: begin
                    if (in_fire && i_s_axis_tlast) begin
                        r_r   <= '0;
                        r_c   <= '0;
                        r_sum <= '0;
                    end
                end
                C_CM_MIN: begin
                    r_m <= cm_min;
                    if (r_r == nm1) begin
                        r_r   <= '0;
                        r_sum <= r_sum + cm_min;
                    end else begin
                        r_r <= r_r + IW'(1);
                    end
                end
                C_CS_WR: begin
                    if (r_r == nm1) begin
                        r_r <= '0;
                        if (r_c != nm1) r_c <= r_c + IW'(1);
                    end else begin
                        r_r <= r_r + IW'(1);
                    end
                end
                C_INIT: begin
                    for (int k = 0; k < MAX_SIZE; k++) begin
                        r_cp[k]    <= NONE;
                        r_par[k]   <= NONE;
                        r_rp[k]    <= NONE;
                        r_inc[k]   <= '0;
                        r_rr[k]    <= '0;
                        r_slack[k] <= SLACK_TOP;
                    end
                    r_cnt <= '0;
                    r_r   <= '0;
                    r_c   <= '0;
                end
                C_GR_MIN: begin
                    r_m <= gr_min;
                    if (r_c == nm1) begin
                        r_rr[r_r] <= gr_min;
                        r_c       <= '0;
                    end else begin
                        r_c <= r_c + IW'(1);
                    end
                end
                C_GM_CHK: begin
                    if ((data_ext == r_m) && cp_none) begin
                        r_rp[r_r] <= {1'b0, r_c};
                        r_cp[r_c] <= {1'b0, r_r};
                    end
                    if (((data_ext == r_m) && cp_none) || r_c == nm1) begin
                        if (r_r != nm1) begin
                            r_r <= r_r + IW'(1);
                            r_c <= '0;
                        end
                    end else begin
                        r_c <= r_c + IW'(1);
                    end
                end
                C_LEFT: begin
                    r_left <= r_cnt;
                    r_head <= '0;
                    r_r    <= '0;
                    r_c    <= '0;
                end
                C_SC_ROW: begin
                    r_c <= '0;
                    if (r_head < r_cnt) begin
                        r_r     <= r_open[r_head[IW-1:0]];
                        r_rnone <= 1'b0;
                        r_base  <= r_rr[r_open[r_head[IW-1:0]]];
                    end else begin
                        r_m <= SLACK_TOP;
                    end
                end
                C_SC_COL: begin
                    if (slack_nz && d < slack_c) begin
                        if (d == '0) begin
                            if (!cp_none) begin
                                r_slack[r_c] <= '0;
                                r_par[r_c]   <= {1'b0, r_r};
                            end
                        end else begin
                            r_slack[r_c] <= d;
                            r_src[r_c]   <= r_r;
                        end
                    end
                    if (!(slack_nz && d < slack_c && d == '0 && cp_none)) begin
                        if (r_c == nm1) r_head <= r_head + CW'(1);
                        else            r_c    <= r_c + IW'(1);
                    end
                end
                C_MN: begin
                    r_m <= mn_new;
                    if (r_c == nm1) begin
                        r_c <= '0;
                        r_x <= '0;
                    end else begin
                        r_c <= r_c + IW'(1);
                    end
                end
                C_RR: begin
                    r_rr[r_open[r_x]] <= r_rr[r_open[r_x]] + r_m;
                    if ((CW'(r_x) + CW'(1)) != r_cnt) r_x <= r_x + IW'(1);
                end
                C_UP: begin
                    if (slack_nz) begin
                        r_slack[r_c] <= slack_sub;
                        if (slack_sub == '0) begin
                            r_r     <= r_src[r_c];
                            r_rnone <= 1'b0;
                            if (cp_none) begin
                                // Later tight columns get the dual step as well.
                                for (int k = 0; k < MAX_SIZE; k++) begin
                                    if (IW'(k) > r_c && IW'(k) <= nm1 && r_slack[k] == '0)
                                        r_inc[k] <= r_inc[k] + r_m;
                                end
                            end else begin
                                r_par[r_c] <= {1'b0, r_src[r_c]};
                            end
                        end
                    end else begin
                        r_inc[r_c] <= r_inc[r_c] + r_m;
                    end
                    if (!(slack_nz && slack_sub == '0 && cp_none) && r_c != nm1)
                        r_c <= r_c + IW'(1);
                end
                C_AUG: begin
                    if (!(r_rnone || r_r > nm1)) begin
                        r_rp[r_r] <= {1'b0, r_c};
                        r_cp[r_c] <= {1'b0, r_r};
                        if (!rp_r[IW]) begin
                            r_r     <= r_par[rp_r[IW-1:0]][IW-1:0];
                            r_rnone <= r_par[rp_r[IW-1:0]][IW];
                            r_c     <= rp_r[IW-1:0];
                        end
                    end
                end
                C_AUG_DONE: begin
                    r_left <= r_left - CW'(1);
                    for (int k = 0; k < MAX_SIZE; k++) begin
                        r_par[k]   <= NONE;
                        r_slack[k] <= SLACK_TOP;
                    end
                    r_cnt <= '0;
                    r_r   <= '0;
                    r_c   <= '0;
                end
                C_RS: begin
                    if (r_r != nm1) r_r    <= r_r + IW'(1);
                    else            r_head <= '0;
                end
                C_CK_USE: begin
                    if (r_c == nm1) begin
                        r_c <= '0;
                        if (r_r == nm1) r_r <= '0;
                        else            r_r <= r_r + IW'(1);
                    end else begin
                        r_c <= r_c + IW'(1);
                    end
                end
                C_CK2_SET: begin
                    if (!rp_r[IW]) r_c <= rp_r[IW-1:0];
                end
                C_CK2_USE: begin
                    if (r_r == nm1) begin
                        r_total <= r_sum;
                        r_r     <= '0;
                    end else begin
                        r_r <= r_r + IW'(1);
                    end
                end
                C_TOT: begin
                    r_total <= r_total + r_rr[r_r] - r_inc[r_r];
                    if (r_r == nm1) r_r <= '0;
                    else            r_r <= r_r + IW'(1);
                end
                C_OUT: begin
                    if (out_fire && r_r != nm1) r_r <= r_r + IW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tdata = is_fail ? '0 :
        {OUT_PAD_W'(0), TOTAL_W'(r_total), OUT_IDX_W'(rp_r[IW-1:0]), OUT_IDX_W'(r_r)};
    assign o_m_axis_tuser = is_fail;
    assign o_m_axis_tlast = is_fail || (r_r == nm1);

    assign o_status.in_last_fire = in_fire && i_s_axis_tlast;
    assign o_status.out_fire     = out_fire;
    assign o_status.r_end        = (r_r == nm1);
    assign o_status.c_end        = (r_c == nm1);
    assign o_status.x_end        = ((CW'(r_x) + CW'(1)) == r_cnt);
    assign o_status.head_more    = (r_head < r_cnt);
    assign o_status.cnt_zero     = (r_cnt == '0);
    assign o_status.left_one     = (r_left == CW'(1));
    assign o_status.gm_match     = (data_ext == r_m) && cp_none;
    assign o_status.sc_hit       = slack_nz && (d < slack_c) && (d == '0) && cp_none;
    assign o_status.up_hit       = slack_nz && (slack_sub == '0) && cp_none;
    assign o_status.mn_top       = (r_m == SLACK_TOP);
    assign o_status.aug_bad      = r_rnone || (r_r > nm1);
    assign o_status.aug_end      = rp_r[IW];
    assign o_status.ck_fail      = (data_ext < dual_rc);
    assign o_status.ck2_bad      = rp_r[IW] || (rp_r[IW-1:0] > nm1);
    assign o_status.ck2_fail     = (data_ext != dual_rc);

endmodule

### hw/rtl/mcas_checker.sv
// ----------------------------------------------------------------------------
// mcas_checker
// Port-level assertions for the assignment solver, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_cost_assignment_solver_assert.svh"

module mcas_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            i_s_axis_tlast,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [mcas_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                            o_m_axis_tuser,
    input logic                            o_m_axis_tlast
);

    // A stalled result word keeps its contents.
    `MCAS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser), "result word changed while stalled")

    // Loading and result output never overlap.
    `MCAS_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_s_axis_tready && o_m_axis_tvalid), "input ready while results pending")

    // A failed run gives one zeroed word that closes the run.
    `MCAS_ASSERT(a_fail_form, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast && (o_m_axis_tdata == '0), "malformed failure word")

    // The final entry starts a solve, so input closes at once.
    `MCAS_ASSERT(a_solve_start, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=> !o_s_axis_tready, "input still open after final entry")

    // Delivering the final result reopens the input.
    `MCAS_ASSERT(a_reopen, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast |=> o_s_axis_tready, "input not reopened after final result")

endmodule

bind min_cost_assignment_solver mcas_checker u_mcas_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
